>>> rtl/core/vcv_pkg.sv
// Package for the vector colour and visibility unit.
// Holds register indexes, colour modes and field widths; no dependencies.
package vcv_pkg;

	localparam int CompW = 16;
	localparam int NumW  = 25;
	localparam int DenW  = 17;
	localparam int QuoW  = 8;

	localparam logic [2:0] RegMode    = 3'd0;
	localparam logic [2:0] RegUniform = 3'd1;
	localparam logic [2:0] RegRampLo  = 3'd2;
	localparam logic [2:0] RegRampHi  = 3'd3;
	localparam logic [2:0] RegThresh  = 3'd4;
	localparam logic [2:0] RegStep    = 3'd5;

	typedef enum logic [1:0] {
		MODE_UNIFORM = 2'd0,
		MODE_RAMP    = 2'd1,
		MODE_DIR     = 2'd2,
		MODE_ALT     = 2'd3
	} colour_mode_t;

	typedef enum logic [1:0] {
		RAMP_DIV  = 2'd0,
		RAMP_ZERO = 2'd1,
		RAMP_FULL = 2'd2
	} ramp_kind_t;

endpackage

>>> rtl/core/vcv_div.sv
// Pipelined restoring divider with an 8-bit quotient, two steps per stage.
// Depends on vcv_pkg; numerator must be below 256 times the divisor.
module vcv_div import vcv_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [NumW-1:0]   num,
	input  logic [DenW-1:0]   den,
	output logic [QuoW-1:0]   quo
);

	logic [NumW-1:0] rem_s [1:4];
	logic [DenW-1:0] den_s [1:4];
	logic [QuoW-1:0] quo_s [1:4];
	logic [NumW-1:0] rem_i [0:3];
	logic [DenW-1:0] den_i [0:3];
	logic [QuoW-1:0] quo_i [0:3];
	logic [NumW-1:0] rem_n [1:4];
	logic [QuoW-1:0] quo_n [1:4];

	always_comb begin
		rem_i[0] = num;
		den_i[0] = den;
		quo_i[0] = '0;
		for (int k = 1; k <= 3; k++) begin
			rem_i[k] = rem_s[k];
			den_i[k] = den_s[k];
			quo_i[k] = quo_s[k];
		end
	end

	always_comb begin
		logic [NumW-1:0] r;
		logic [NumW-1:0] dsh;
		logic [QuoW-1:0] q;
		for (int k = 1; k <= 4; k++) begin
			r = rem_i[k-1];
			q = quo_i[k-1];
			for (int j = 0; j < 2; j++) begin
				dsh = NumW'({{(NumW-DenW){1'b0}}, den_i[k-1]} << (QuoW - 2*(k-1) - j - 1));
				if (r >= dsh) begin
					r = r - dsh;
					q[QuoW - 2*(k-1) - j - 1] = 1'b1;
				end
			end
			rem_n[k] = r;
			quo_n[k] = q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= 4; k++) begin
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
				den_s[k] <= den_i[k-1];
			end
		end
	end

	assign quo = quo_s[4];

endmodule

>>> rtl/core/vector_colour_and_visibility.sv
// Vector colour and visibility unit: magnitude, subsample/threshold test, RGB colour.
// Depends on vcv_pkg and vcv_div.
// Throughput: one word per cycle while the output register is empty or taken.
// The pipeline advances as a whole whenever the output register is empty or taken.
// Squares, 8 stages of square root and index modulo, 4 stages of division.
// Reset clears all valid bits and loads the register defaults.
module vector_colour_and_visibility import vcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // vec_x, vec_y, vec_z, vec_index
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // red, green, blue, magnitude
	output logic [0:0]  m_tuser,   // shown
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]  mode_q;
	logic [23:0] uniform_q;
	logic [15:0] ramp_lo_q;
	logic [15:0] ramp_hi_q;
	logic [15:0] thresh_q;
	logic [7:0]  step_q;
	logic [7:0]  step_eff;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_UNIFORM;
			uniform_q <= 24'hFFFFFF;
			ramp_lo_q <= 16'd0;
			ramp_hi_q <= 16'd256;
			thresh_q  <= 16'd0;
			step_q    <= 8'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				RegMode:    mode_q    <= pwdata[1:0];
				RegUniform: uniform_q <= pwdata[23:0];
				RegRampLo:  ramp_lo_q <= pwdata[15:0];
				RegRampHi:  ramp_hi_q <= pwdata[15:0];
				RegThresh:  thresh_q  <= pwdata[15:0];
				RegStep:    step_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			RegMode:    prdata = {30'd0, mode_q};
			RegUniform: prdata = {8'd0, uniform_q};
			RegRampLo:  prdata = {16'd0, ramp_lo_q};
			RegRampHi:  prdata = {16'd0, ramp_hi_q};
			RegThresh:  prdata = {16'd0, thresh_q};
			RegStep:    prdata = {24'd0, step_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign step_eff = (step_q == 8'd0) ? 8'd1 : step_q;

	logic adv;
	logic valid_s [1:16];

	assign adv      = !valid_s[16] || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 16; k++) valid_s[k] <= 1'b0;
		end else if (adv) begin
			valid_s[1] <= s_tvalid;
			for (int k = 2; k <= 16; k++) valid_s[k] <= valid_s[k-1];
		end
	end

	// squares and sum
	logic signed [CompW-1:0] vx_s [1:10];
	logic signed [CompW-1:0] vy_s [1:10];
	logic signed [CompW-1:0] vz_s [1:10];
	logic [15:0] idx_s [1:10];
	logic [30:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [CompW-1:0] in_x, in_y, in_z;

	assign in_x = s_tdata[15:0];
	assign in_y = s_tdata[31:16];
	assign in_z = s_tdata[47:32];

	logic [31:0] rad_s [2:10];
	logic [18:0] srem_s [2:10];
	logic [15:0] sres_s [2:10];
	logic [7:0]  mrem_s [2:10];
	logic [31:0] rad_n [3:10];
	logic [18:0] srem_n [3:10];
	logic [15:0] sres_n [3:10];
	logic [7:0]  mrem_n [3:10];
	logic [15:0] idx_n [3:10];

	always_comb begin
		logic [18:0] r;
		logic [18:0] t;
		logic [15:0] q;
		logic [31:0] a;
		logic [8:0]  w;
		logic [7:0]  m;
		logic [15:0] i;
		for (int k = 3; k <= 10; k++) begin
			r = srem_s[k-1];
			q = sres_s[k-1];
			a = rad_s[k-1];
			m = mrem_s[k-1];
			i = idx_s[k-1];
			for (int j = 0; j < 2; j++) begin
				r = {r[16:0], a[31:30]};
				a = {a[29:0], 2'b00};
				t = {1'b0, q, 2'b01};
				if (r >= t) begin
					r = r - t;
					q = {q[14:0], 1'b1};
				end else begin
					q = {q[14:0], 1'b0};
				end
				w = {m, i[15]};
				i = {i[14:0], 1'b0};
				if (w >= {1'b0, step_eff}) w = w - {1'b0, step_eff};
				m = w[7:0];
			end
			srem_n[k] = r;
			sres_n[k] = q;
			rad_n[k]  = a;
			mrem_n[k] = m;
			idx_n[k]  = i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s[1]  <= in_x;
			vy_s[1]  <= in_y;
			vz_s[1]  <= in_z;
			idx_s[1] <= s_tdata[63:48];
			sqx_s1   <= 31'(unsigned'(32'(in_x) * 32'(in_x)));
			sqy_s1   <= 31'(unsigned'(32'(in_y) * 32'(in_y)));
			sqz_s1   <= 31'(unsigned'(32'(in_z) * 32'(in_z)));
			for (int k = 2; k <= 10; k++) begin
				vx_s[k] <= vx_s[k-1];
				vy_s[k] <= vy_s[k-1];
				vz_s[k] <= vz_s[k-1];
			end
			idx_s[2]  <= idx_s[1];
			rad_s[2]  <= 32'(sqx_s1) + 32'(sqy_s1) + 32'(sqz_s1);
			srem_s[2] <= '0;
			sres_s[2] <= '0;
			mrem_s[2] <= '0;
			for (int k = 3; k <= 10; k++) begin
				rad_s[k]  <= rad_n[k];
				srem_s[k] <= srem_n[k];
				sres_s[k] <= sres_n[k];
				mrem_s[k] <= mrem_n[k];
				idx_s[k]  <= idx_n[k];
			end
		end
	end

	// setup of ramp and direction divisions
	logic [15:0] mag10;
	logic signed [17:0] rn, rd, rn_a, rd_a;
	ramp_kind_t  rkind_c;
	logic [NumW-1:0] rnum_c, xnum_c, ynum_c, znum_c;
	logic [17:0] xl, yl, zl;

	assign mag10 = sres_s[10];

	always_comb begin
		rn = 18'(signed'({2'b00, mag10})) - 18'(signed'({2'b00, ramp_lo_q}));
		rd = 18'(signed'({2'b00, ramp_hi_q})) - 18'(signed'({2'b00, ramp_lo_q}));
		rn_a = rn;
		rd_a = rd;
		if (rd < 0) begin
			rn_a = -rn;
			rd_a = -rd;
		end
		if (rd == 0)
			rkind_c = (rn >= 0) ? RAMP_FULL : RAMP_ZERO;
		else if (rn_a <= 0)
			rkind_c = RAMP_ZERO;
		else if (rn_a >= rd_a)
			rkind_c = RAMP_FULL;
		else
			rkind_c = RAMP_DIV;
		rnum_c = NumW'({rn_a[16:0], 8'd0} - {8'd0, rn_a[16:0]}) + NumW'(rd_a[16:1]);
		xl = 18'(vx_s[10]) + 18'({2'b00, mag10});
		yl = 18'(vy_s[10]) + 18'({2'b00, mag10});
		zl = 18'(vz_s[10]) + 18'({2'b00, mag10});
		xnum_c = NumW'({xl, 8'd0} - {8'd0, xl}) + NumW'(mag10);
		ynum_c = NumW'({yl, 8'd0} - {8'd0, yl}) + NumW'(mag10);
		znum_c = NumW'({zl, 8'd0} - {8'd0, zl}) + NumW'(mag10);
	end

	logic [NumW-1:0] rnum_s11, xnum_s11, ynum_s11, znum_s11;
	logic [DenW-1:0] rden_s11;
	logic [15:0] mag_s [11:15];
	logic        shown_s [11:15];
	ramp_kind_t  rkind_s [11:15];
	logic        zero_s [11:15];

	always_ff @(posedge clk) begin
		if (adv) begin
			rnum_s11     <= rnum_c;
			rden_s11     <= (rkind_c == RAMP_DIV) ? rd_a[16:0] : DenW'(1);
			xnum_s11     <= xnum_c;
			ynum_s11     <= ynum_c;
			znum_s11     <= znum_c;
			mag_s[11]    <= mag10;
			shown_s[11]  <= (mrem_s[10] == 8'd0) && (mag10 >= thresh_q);
			rkind_s[11]  <= rkind_c;
			zero_s[11]   <= (mag10 == 16'd0);
			for (int k = 12; k <= 15; k++) begin
				mag_s[k]   <= mag_s[k-1];
				shown_s[k] <= shown_s[k-1];
				rkind_s[k] <= rkind_s[k-1];
				zero_s[k]  <= zero_s[k-1];
			end
		end
	end

	logic [DenW-1:0] lden;
	logic [QuoW-1:0] rq, xq, yq, zq;

	assign lden = zero_s[11] ? DenW'(1) : {mag_s[11], 1'b0};

	vcv_div u_ramp_div (.clk(clk), .en(adv), .num(rnum_s11), .den(rden_s11), .quo(rq));
	vcv_div u_x_div    (.clk(clk), .en(adv), .num(xnum_s11), .den(lden),     .quo(xq));
	vcv_div u_y_div    (.clk(clk), .en(adv), .num(ynum_s11), .den(lden),     .quo(yq));
	vcv_div u_z_div    (.clk(clk), .en(adv), .num(znum_s11), .den(lden),     .quo(zq));

	// colour select into the output register
	logic [7:0] red_c, green_c, blue_c, ramp_red;
	logic [7:0] red_s16, green_s16, blue_s16;
	logic [15:0] mag_s16;
	logic        shown_s16;

	always_comb begin
		case (rkind_s[15])
			RAMP_ZERO: ramp_red = 8'd0;
			RAMP_FULL: ramp_red = 8'd255;
			default:   ramp_red = rq;
		endcase
		case (mode_q)
			MODE_RAMP: begin
				red_c   = ramp_red;
				green_c = 8'd0;
				blue_c  = 8'd255 - ramp_red;
			end
			MODE_DIR: begin
				red_c   = zero_s[15] ? 8'd128 : xq;
				green_c = zero_s[15] ? 8'd128 : yq;
				blue_c  = zero_s[15] ? 8'd128 : zq;
			end
			default: begin
				red_c   = uniform_q[23:16];
				green_c = uniform_q[15:8];
				blue_c  = uniform_q[7:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			red_s16   <= red_c;
			green_s16 <= green_c;
			blue_s16  <= blue_c;
			mag_s16   <= mag_s[15];
			shown_s16 <= shown_s[15];
		end
	end

	assign m_tvalid = valid_s[16];
	assign m_tdata  = {mag_s16, blue_s16, green_s16, red_s16};
	assign m_tuser  = shown_s16;

endmodule

>>> tb/vector_colour_and_visibility_test.sv
// Testbench for vector_colour_and_visibility: random and directed vectors through all colour modes.
// Predicts magnitude, visibility and colour per word and checks each output word in order.
// Depends on vcv_pkg and the RTL of the unit.
module vector_colour_and_visibility_test import vcv_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        shown;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] magnitude;
	} colour_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	colour_mode_t mode_q;
	logic [23:0]  uniform_q;
	logic [15:0]  ramp_lo_q, ramp_hi_q, thresh_q;
	logic [7:0]   step_q;

	colour_word_t expected_words[$];
	int           mismatches = 0;
	int           words_checked = 0;
	int           vectors_sent = 0;
	int           out_wait = 0;
	bit           stall_enable = 1'b1;

	vector_colour_and_visibility i_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#8000000;
		$display("vector_colour_and_visibility_test: done, errors");
		$finish;
	end

	function automatic longint int_sqrt(longint v);
		longint res, bitv;
		res = 0;
		bitv = 64'sh1 << 60;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [7:0] direction_channel(longint c, longint len);
		longint num, q;
		if (len <= 0)
			return 8'd128;
		num = (c + len) * 255 + len;
		if (num <= 0)
			return 8'd0;
		q = num / (2 * len);
		return q > 255 ? 8'd255 : q[7:0];
	endfunction

	function automatic logic [7:0] ramp_red(longint mag);
		longint n, d;
		n = mag - longint'(ramp_lo_q);
		d = longint'(ramp_hi_q) - longint'(ramp_lo_q);
		if (d == 0)
			return n >= 0 ? 8'd255 : 8'd0;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		if (n <= 0)
			return 8'd0;
		if (n >= d)
			return 8'd255;
		return 8'((n * 255 + d / 2) / d);
	endfunction

	function automatic colour_word_t predict_colour(logic [63:0] data);
		longint x, y, z, mag;
		logic [15:0] idx;
		int stepv;
		colour_word_t w;
		x = longint'($signed(data[15:0]));
		y = longint'($signed(data[31:16]));
		z = longint'($signed(data[47:32]));
		idx = data[63:48];
		mag = int_sqrt(x * x + y * y + z * z);
		if (mag > 65535)
			mag = 65535;
		stepv = step_q == 0 ? 1 : int'(step_q);
		w.magnitude = mag[15:0];
		w.shown = (int'(idx) % stepv == 0) && (mag >= longint'(thresh_q));
		case (mode_q)
			MODE_RAMP: begin
				w.red = ramp_red(mag);
				w.green = 8'd0;
				w.blue = 8'd255 - w.red;
			end
			MODE_DIR: begin
				w.red = direction_channel(x, mag);
				w.green = direction_channel(y, mag);
				w.blue = direction_channel(z, mag);
			end
			default: begin
				w.red = uniform_q[23:16];
				w.green = uniform_q[15:8];
				w.blue = uniform_q[7:0];
			end
		endcase
		return w;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			RegMode:    mode_q = colour_mode_t'(value[1:0]);
			RegUniform: uniform_q = value[23:0];
			RegRampLo:  ramp_lo_q = value[15:0];
			RegRampHi:  ramp_hi_q = value[15:0];
			RegThresh:  thresh_q = value[15:0];
			RegStep:    step_q = value[7:0];
			default: ;
		endcase
	endtask

	task automatic send_vector(logic [15:0] x, logic [15:0] y, logic [15:0] z,
		logic [15:0] idx);
		int gap;
		gap = stall_enable ? $urandom_range(0, 14) : 0;
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {idx, z, y, x};
		expected_words.insert(expected_words.size(), predict_colour({idx, z, y, x}));
		@(posedge clk iff s_tready);
		vectors_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	always @(posedge clk) begin
		colour_word_t got, exp_w;
		if (m_tvalid && m_tready) begin
			got = {m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[39:24]};
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h", got);
			end else begin
				exp_w = expected_words.pop_front();
				words_checked++;
				if (got !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: shown %b/%b rgb %h%h%h/%h%h%h mag %h/%h",
							exp_w.shown, got.shown, exp_w.red, exp_w.green, exp_w.blue,
							got.red, got.green, got.blue, exp_w.magnitude, got.magnitude);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!stall_enable) begin
			out_wait = 0;
			m_tready <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			out_wait = $urandom_range(0, 14);
			m_tready <= (out_wait == 0);
		end else if (out_wait > 0) begin
			out_wait--;
			m_tready <= (out_wait == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [15:0] random_component();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 1200)) - 600);
			2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return 16'($signed($urandom_range(0, 40)) - 20);
		endcase
	endfunction

	task automatic test_directed();
		for (int m = 0; m < 4; m++) begin
			write_reg(RegMode, m);
			send_vector(16'h0000, 16'h0000, 16'h0000, 16'd0);
			send_vector(16'h8000, 16'h8000, 16'h8000, 16'hffff);
			send_vector(16'h7fff, 16'h7fff, 16'h7fff, 16'd3);
			send_vector(16'h0100, 16'h0000, 16'h0000, 16'd4);
			send_vector(16'h0000, 16'hff00, 16'h0000, 16'd5);
			send_vector(16'h0000, 16'h0000, 16'h0080, 16'd6);
			drain();
		end
	endtask

	task automatic test_step_ramp();
		write_reg(RegMode, MODE_RAMP);
		write_reg(RegRampLo, 32'd300);
		write_reg(RegRampHi, 32'd300);
		send_vector(16'd300, 16'd0, 16'd0, 16'd1);
		send_vector(16'd299, 16'd0, 16'd0, 16'd1);
		drain();
		write_reg(RegRampLo, 32'd0);
		write_reg(RegRampHi, 32'd0);
		send_vector(16'd0, 16'd0, 16'd0, 16'd1);
		drain();
	endtask

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++)
			send_vector(random_component(), random_component(), random_component(),
				16'($urandom));
		drain();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 12; phase++) begin
			stall_enable = (phase % 4) != 3;
			write_reg(RegMode, $urandom_range(0, 3));
			write_reg(RegUniform, $urandom);
			case (phase % 3)
				0: begin
					write_reg(RegRampLo, $urandom_range(0, 1000));
					write_reg(RegRampHi, $urandom_range(0, 1000));
				end
				1: begin
					write_reg(RegRampLo, 32'hffff);
					write_reg(RegRampHi, 32'h0000);
				end
				default: begin
					write_reg(RegRampLo, $urandom_range(0, 65535));
					write_reg(RegRampHi, $urandom_range(0, 65535));
				end
			endcase
			write_reg(RegThresh, phase == 0 ? 32'hffff : $urandom_range(0, 900));
			write_reg(RegStep, phase == 1 ? 32'd0 : phase == 2 ? 32'd255 :
				$urandom_range(1, 7));
			random_phase(110);
		end
		stall_enable = 1'b1;
	endtask

	initial begin
		mode_q = MODE_UNIFORM;
		uniform_q = 24'hffffff;
		ramp_lo_q = 16'd0;
		ramp_hi_q = 16'd256;
		thresh_q = 16'd0;
		step_q = 8'd1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_reg(RegUniform, 32'h123456);
		test_directed();
		test_step_ramp();
		test_random_settings();
		$display("ran %0d vectors, checked %0d words over all colour modes and settings",
			vectors_sent, words_checked);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("vector_colour_and_visibility_test: done, clean");
		else
			$display("vector_colour_and_visibility_test: done, errors");
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/vcv_pkg.sv
rtl/core/vcv_div.sv
rtl/core/vector_colour_and_visibility.sv
tb/vector_colour_and_visibility_test.sv
